[rtl/core/arm_pkg.sv]
// ----------------------------------------------------------------------------
// arm_pkg
// Shared types and constants of the audio level meter.
// ----------------------------------------------------------------------------
package arm_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT = 2'd2;

  localparam int DEC_W   = 7;
  localparam int GAIN_W  = 10;
  localparam int LIMIT_W = 15;

  localparam logic [DEC_W-1:0]   DEC_RESET   = 7'd16;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 10'd50;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd20000;

  localparam logic [DEC_W-1:0] DEC_MAX = 7'd64;
  localparam int PHASE_W = 6;

  // datapath
  localparam int RAW_W    = 32;
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 15;
  localparam int SQ_W     = 30;   // square of a 15-bit magnitude

  // two-entry queues
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [LEVEL_W-1:0]  level;
    logic                level_valid;
  } result_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] level;
  } root_res_t;

endpackage

[rtl/core/arm_fifo.sv]
// ----------------------------------------------------------------------------
// arm_fifo
// Two-entry queue with registered storage, used on both sides of the core.
// ----------------------------------------------------------------------------
module arm_fifo #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import arm_pkg::*;

  logic [WIDTH-1:0]      mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

[rtl/core/arm_front.sv]
// ----------------------------------------------------------------------------
// arm_front
// Takes raw words, keeps one in every decimation and queues its top half.
// ----------------------------------------------------------------------------
module arm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic [arm_pkg::RAW_W-1:0]     in_raw_sample,
  output logic                          in_full,
  input  logic [arm_pkg::DEC_W-1:0]     decimation,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [arm_pkg::SAMPLE_W-1:0]  q_data
);
  import arm_pkg::*;

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [DEC_W-1:0]   dec_eff;
  logic [DEC_W-1:0]   phase_inc;
  logic               accept;

  // zero acts as one, large values saturate
  always_comb begin
    if (decimation == '0) dec_eff = DEC_W'(1);
    else if (decimation > DEC_MAX) dec_eff = DEC_MAX;
    else dec_eff = decimation;
  end

  assign accept    = in_push && !q_full;
  assign in_full   = q_full;
  assign phase_inc = {1'b0, phase_r} + DEC_W'(1);
  assign phase_nxt = (phase_inc >= dec_eff) ? '0 : phase_inc[PHASE_W-1:0];
  assign q_push    = accept && (phase_r == '0);
  assign q_data    = in_raw_sample[RAW_W-1 -: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

[rtl/core/arm_root.sv]
// ----------------------------------------------------------------------------
// arm_root
// Window level unit: digit-by-digit integer square root of the window mean.
// Each trial square is scaled by the window length and compared with the sum,
// so the mean itself is never formed. Per bit: a square step, then a compare.
// ----------------------------------------------------------------------------
module arm_root #(
  parameter int WINDOW_LEN = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic [arm_pkg::SQ_W+$clog2(WINDOW_LEN)-1:0] value,
  output arm_pkg::root_res_t                        res
);
  import arm_pkg::*;

  localparam int SUM_W = SQ_W + $clog2(WINDOW_LEN);
  localparam logic [SUM_W-1:0] WIN_K = SUM_W'(WINDOW_LEN);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_SQ   = 2'd1;
  localparam logic [1:0] R_CMP  = 2'd2;

  logic [1:0]         state_r;
  logic [SUM_W-1:0]   val_r;
  logic [LEVEL_W-1:0] root_r;
  logic [LEVEL_W-1:0] bit_r;
  logic [SQ_W-1:0]    sq_r;
  logic               done_r;

  logic [LEVEL_W-1:0] trial;
  logic [SQ_W-1:0]    trial_ext;
  logic [SUM_W-1:0]   scaled;
  logic               fits;

  // r*r <= floor(sum/len) exactly when len*r*r <= sum
  assign trial     = root_r | bit_r;
  assign trial_ext = SQ_W'(trial);
  assign scaled    = SUM_W'(sq_r) * WIN_K;
  assign fits      = (scaled <= val_r);

  assign res.done  = done_r;
  assign res.level = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        R_IDLE: begin
          if (start) state_r <= R_SQ;
        end
        R_SQ: begin
          state_r <= R_CMP;
        end
        R_CMP: begin
          if (bit_r[0]) begin
            state_r <= R_IDLE;
            done_r  <= 1'b1;
          end else begin
            state_r <= R_SQ;
          end
        end
        default: begin
          state_r <= R_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == R_IDLE && start) begin
      val_r  <= value;
      root_r <= '0;
      bit_r  <= {1'b1, {(LEVEL_W-1){1'b0}}};
    end else if (state_r == R_SQ) begin
      sq_r <= trial_ext * trial_ext;
    end else if (state_r == R_CMP) begin
      if (fits) root_r <= trial;
      bit_r <= bit_r >> 1;
    end
  end

endmodule

[rtl/core/arm_back.sv]
// ----------------------------------------------------------------------------
// arm_back
// Sample pipeline: DC removal, gain, clamp, square and window accumulate,
// with the level unit run once per closed window.
// ----------------------------------------------------------------------------
module arm_back #(
  parameter int WINDOW_LEN = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [arm_pkg::SAMPLE_W-1:0]  q_data,
  output logic                          q_pop,
  input  logic [arm_pkg::GAIN_W-1:0]    gain,
  input  logic [arm_pkg::LIMIT_W-1:0]   clamp_limit,
  input  logic                          out_full,
  output logic                          out_push,
  output arm_pkg::result_t              out_data
);
  import arm_pkg::*;

  localparam int SUM_W  = 30 + $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN);
  localparam int ACC_W  = SAMPLE_W + 7;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;

  // stage 1: dc estimate and difference
  logic signed [SAMPLE_W-1:0] dc_r;
  logic                       v1_r;
  logic signed [DIFF_W-1:0]   diff1_r;
  // stage 2: gain product
  logic                       v2_r;
  logic signed [PROD_W-1:0]   prod2_r;
  // stage 3: clamped sample and square
  logic                       v3_r;
  logic [SAMPLE_W-1:0]        d3_r;
  logic [SQ_W-1:0]            sq3_r;
  // window
  logic [SUM_W-1:0]           sum_r;
  logic [FILL_W-1:0]          fill_r;
  // result holding register
  logic                       res_v_r;
  logic                       res_wait_r;
  logic [SAMPLE_W-1:0]        res_d_r;
  logic [LEVEL_W-1:0]         res_lvl_r;
  logic                       res_flag_r;

  logic                       adv;
  logic                       res_push;
  logic signed [SAMPLE_W-1:0] s_c;
  logic signed [ACC_W-1:0]    dc_ext;
  logic signed [ACC_W-1:0]    s_ext;
  logic signed [ACC_W-1:0]    dc_acc;
  logic signed [ACC_W-1:0]    dc_shift;
  logic signed [SAMPLE_W-1:0] dc_nxt;
  logic signed [DIFF_W-1:0]   diff_c;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]   lim_pos;
  logic signed [PROD_W-1:0]   lim_neg;
  logic signed [PROD_W-1:0]   clamp_c;
  logic [SAMPLE_W-1:0]        d_c;
  logic [SAMPLE_W-1:0]        mag_c;
  logic [SUM_W-1:0]           sum_tot;
  logic                       close_c;
  logic                       root_start;
  root_res_t                  root_res;

  assign res_push = res_v_r && !res_wait_r && !out_full;
  assign adv      = !res_v_r || res_push;
  assign q_pop    = adv && !q_empty;

  // dc = floor((dc*63 + s)/64)
  assign s_c      = $signed(q_data);
  assign dc_ext   = ACC_W'(dc_r);
  assign s_ext    = ACC_W'(s_c);
  assign dc_acc   = (dc_ext <<< 6) - dc_ext + s_ext;
  assign dc_shift = dc_acc >>> 6;
  assign dc_nxt   = dc_shift[SAMPLE_W-1:0];
  assign diff_c   = DIFF_W'(s_c) - DIFF_W'(dc_nxt);

  assign gain_s   = $signed({1'b0, gain});
  assign lim_pos  = $signed(PROD_W'(clamp_limit));
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (prod2_r > lim_pos) clamp_c = lim_pos;
    else if (prod2_r < lim_neg) clamp_c = lim_neg;
    else clamp_c = prod2_r;
  end

  assign d_c   = clamp_c[SAMPLE_W-1:0];
  assign mag_c = d_c[SAMPLE_W-1] ? (~d_c + 1'b1) : d_c;

  assign sum_tot    = sum_r + SUM_W'(sq3_r);
  assign close_c    = (fill_r == FILL_W'(WINDOW_LEN - 1));
  assign root_start = adv && v3_r && close_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r       <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      sum_r      <= '0;
      fill_r     <= '0;
      res_v_r    <= 1'b0;
      res_wait_r <= 1'b0;
    end else begin
      if (adv) begin
        v1_r    <= q_pop;
        v2_r    <= v1_r;
        v3_r    <= v2_r;
        res_v_r <= v3_r;
        if (q_pop) dc_r <= dc_nxt;
        if (v3_r) begin
          res_wait_r <= close_c;
          if (close_c) begin
            sum_r  <= '0;
            fill_r <= '0;
          end else begin
            sum_r  <= sum_tot;
            fill_r <= fill_r + 1'b1;
          end
        end
      end else if (root_res.done) begin
        res_wait_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff1_r <= diff_c;
      prod2_r <= diff1_r * gain_s;
      d3_r    <= d_c;
      sq3_r   <= SQ_W'(mag_c[LEVEL_W-1:0] * mag_c[LEVEL_W-1:0]);
      if (v3_r) begin
        res_d_r    <= d3_r;
        res_flag_r <= close_c;
        res_lvl_r  <= '0;
      end
    end else if (root_res.done) begin
      res_lvl_r <= root_res.level;
    end
  end

  arm_root #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (sum_tot),
    .res   (root_res)
  );

  assign out_push             = res_push;
  assign out_data.sample      = res_d_r;
  assign out_data.level       = res_lvl_r;
  assign out_data.level_valid = res_flag_r;

endmodule

[rtl/core/audio_rms_level_meter_core.sv]
// ----------------------------------------------------------------------------
// audio_rms_level_meter_core
// A kept word passes the sample queue, the DC, gain and square stages and the
// result holding register into the result queue; one that closes a window
// waits there for the square root (a square and a compare step per level bit,
// then the level hand-over). Throughput: one raw word a cycle while the sample
// queue has room; the level unit holds the sample pipe once per window. Reset
// (synchronous, active low) empties the queues, clears state, loads defaults.
// ----------------------------------------------------------------------------
module audio_rms_level_meter_core #(
  parameter int WINDOW_LEN = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [arm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_push,
  input  logic [arm_pkg::RAW_W-1:0]       in_raw_sample,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [arm_pkg::SAMPLE_W-1:0]    out_conditioned_sample,
  output logic [arm_pkg::LEVEL_W-1:0]     out_level,
  output logic                            out_level_valid
);
  import arm_pkg::*;

  logic [DEC_W-1:0]    dec_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [LIMIT_W-1:0]  lim_r;

  logic                q_push;
  logic [SAMPLE_W-1:0] q_wdata;
  logic                q_full;
  logic                q_pop;
  logic [SAMPLE_W-1:0] q_rdata;
  logic                q_empty;
  logic                r_push;
  result_t             r_wdata;
  logic                r_full;
  result_t             r_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r  <= DEC_RESET;
      gain_r <= GAIN_RESET;
      lim_r  <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DECIMATION:  dec_r  <= cfg_wdata[DEC_W-1:0];
        REG_GAIN:        gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_CLAMP_LIMIT: lim_r  <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  arm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_raw_sample (in_raw_sample),
    .in_full       (in_full),
    .decimation    (dec_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  arm_fifo #(
    .WIDTH (SAMPLE_W)
  ) u_sample_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  arm_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .gain        (gain_r),
    .clamp_limit (lim_r),
    .out_full    (r_full),
    .out_push    (r_push),
    .out_data    (r_wdata)
  );

  arm_fifo #(
    .WIDTH ($bits(result_t))
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .wdata (r_wdata),
    .full  (r_full),
    .pop   (out_pop),
    .rdata (r_rdata),
    .empty (out_empty)
  );

  assign out_conditioned_sample = r_rdata.sample;
  assign out_level              = r_rdata.level;
  assign out_level_valid        = r_rdata.level_valid;

`ifndef SYNTHESIS
  // level reads zero unless the item closes a window
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_level_valid) |-> (out_level == '0))
    else $error("level set on an item that does not close a window");

  // conditioned sample stays inside the clamp bounds
  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |->
      (($signed(out_conditioned_sample) <= $signed({1'b0, lim_r})) &&
       ($signed(out_conditioned_sample) >= -$signed({1'b0, lim_r}))))
    else $error("conditioned sample outside clamp limit");

  // sample queue is only drained when it holds an item
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("sample queue popped while empty");
`endif

endmodule

[tb/audio_rms_level_meter_core_tb.sv]
// ----------------------------------------------------------------------------
// audio_rms_level_meter_core_tb
// Self-checking bench for the decimating DC blocker and windowed RMS meter.
// A local predictor follows every accepted raw word and queues the result
// that each kept word should produce. A checker pops results under random
// back-pressure and compares them field by field. Register settings change
// only between phases, once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module audio_rms_level_meter_core_tb;
  import arm_pkg::*;

  localparam int WINDOW_LEN     = 32;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_push = 1'b0;
  logic [RAW_W-1:0]      in_raw_sample = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [SAMPLE_W-1:0]   out_conditioned_sample;
  logic [LEVEL_W-1:0]    out_level;
  logic                  out_level_valid;

  audio_rms_level_meter_core #(
    .WINDOW_LEN(WINDOW_LEN)
  ) uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_push                (in_push),
    .in_raw_sample          (in_raw_sample),
    .in_full                (in_full),
    .out_empty              (out_empty),
    .out_pop                (out_pop),
    .out_conditioned_sample (out_conditioned_sample),
    .out_level              (out_level),
    .out_level_valid        (out_level_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // register copies and meter state as the block should hold them
  logic [DEC_W-1:0]     dec_q   = DEC_RESET;
  logic [GAIN_W-1:0]    gain_q  = GAIN_RESET;
  logic [LIMIT_W-1:0]   limit_q = LIMIT_RESET;
  logic [PHASE_W-1:0]   decim_phase = '0;
  logic signed [15:0]   dc_est = '0;
  logic [34:0]          sq_sum = '0;
  logic [4:0]           win_fill = '0;

  result_t expected_q[$];
  result_t want;
  int      mismatches = 0;
  bit      calm = 1'b0;
  int      pop_hold = 0;
  int      quiet = 0;

  function automatic logic [LEVEL_W-1:0] int_sqrt(input logic [31:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = LEVEL_W - 1; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[LEVEL_W-1:0];
  endfunction

  // follows one accepted raw word; queues a result when the word is kept
  function automatic void condition_word(input logic [RAW_W-1:0] raw);
    logic [6:0]  eff_dec;
    logic [6:0]  next_phase;
    bit          keep;
    int          s;
    int          dcv;
    int          d;
    int          lim;
    int          g;
    longint      mag;
    logic [34:0] sum_next;
    result_t     r;
    eff_dec = (dec_q == 0) ? 7'd1 : ((dec_q > DEC_MAX) ? DEC_MAX : dec_q);
    keep = (decim_phase == 0);
    next_phase = {1'b0, decim_phase} + 7'd1;
    decim_phase = (next_phase >= eff_dec) ? '0 : next_phase[PHASE_W-1:0];
    if (!keep) return;
    s = int'($signed(raw[31:16]));
    dcv = int'(dc_est);
    dcv = (dcv * 63 + s) >>> 6;
    dc_est = dcv[15:0];
    g = int'(gain_q);
    lim = int'(limit_q);
    d = (s - dcv) * g;
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    mag = longint'((d < 0) ? -d : d);
    sum_next = sq_sum + 35'(mag * mag);
    r.sample = d[SAMPLE_W-1:0];
    r.level = '0;
    r.level_valid = 1'b0;
    if (win_fill == 5'(WINDOW_LEN - 1)) begin
      r.level = int_sqrt(32'(sum_next / WINDOW_LEN));
      r.level_valid = 1'b1;
      sq_sum = '0;
      win_fill = '0;
    end else begin
      sq_sum = sum_next;
      win_fill = win_fill + 5'd1;
    end
    expected_q.push_back(r);
  endfunction

  task automatic send_item(input logic [RAW_W-1:0] raw);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_raw_sample <= raw;
    @(posedge clk);
    while (in_full) @(posedge clk);
    condition_word(raw);
  endtask

  // leaves the write enable high so that writes can follow back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_DECIMATION:  dec_q = val[DEC_W-1:0];
      REG_GAIN:        gain_q = val[GAIN_W-1:0];
      REG_CLAMP_LIMIT: limit_q = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] dec, input logic [CFG_DATA_W-1:0] g,
                            input logic [CFG_DATA_W-1:0] lim);
    write_reg(REG_DECIMATION, dec);
    write_reg(REG_GAIN, g);
    write_reg(REG_CLAMP_LIMIT, lim);
    cfg_wr_en <= 1'b0;
  endtask

  // skipped words leave nothing to wait for, so allow the full level latency
  task automatic drain_and_settle;
    in_push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [RAW_W-1:0] gen_raw(input int bias, input int amp);
    int top;
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        top = bias + $urandom_range(0, 2 * amp) - amp;
        return {top[15:0], 16'($urandom)};
      end
    endcase
  endfunction

  task automatic test_reset_config;
    // one kept word then three skipped ones under the reset settings
    send_item(32'h1234_5678);
    send_item(32'hFFFF_0000);
    send_item(32'h7FFF_FFFF);
    send_item(32'h8000_0000);
  endtask

  task automatic test_raw_extremes;
    drain_and_settle();
    set_config(15'd1, 15'd1, 15'd32767);
    send_item(32'h7FFF_FFFF);
    send_item(32'h8000_0000);
    send_item(32'h0000_0000);
    send_item(32'hFFFF_FFFF);
    send_item(32'h0000_FFFF);
    send_item(32'hFFFF_0000);
  endtask

  task automatic test_gain_and_limit;
    drain_and_settle();
    set_config(15'd1, 15'd0, 15'd32767);
    send_item(32'h7FFF_0000);
    send_item(32'h8000_0000);
    drain_and_settle();
    set_config(15'd1, 15'd1023, 15'd0);
    send_item(32'h4000_0000);
    send_item(32'hC000_0000);
    drain_and_settle();
    set_config(15'd1, 15'd1023, 15'd32767);
    send_item(32'h7FFF_FFFF);
    send_item(32'h8000_0000);
    drain_and_settle();
    set_config(15'd1, 15'd1023, 15'd1);
    send_item(32'h0100_0000);
  endtask

  task automatic test_decimation_bounds;
    drain_and_settle();
    // zero acts as one
    set_config(15'd0, 15'd7, 15'd30000);
    send_item(32'h0400_0000);
    send_item(32'hFC00_0000);
    drain_and_settle();
    // upper data bits are dropped, then 127 saturates to 64
    set_config(15'h7FFF, 15'h7FFF, 15'd12345);
    send_item(32'h2000_0000);
    send_item(32'hE000_0000);
    send_item(32'h1000_0000);
    drain_and_settle();
    write_reg(REG_SPARE, 15'h7FFF);
    write_reg(REG_DECIMATION, 15'd65);
    cfg_wr_en <= 1'b0;
    send_item(32'h0800_0000);
    send_item(32'hF800_0000);
  endtask

  task automatic test_random_settings;
    logic [CFG_DATA_W-1:0] dec;
    logic [CFG_DATA_W-1:0] g;
    logic [CFG_DATA_W-1:0] lim;
    int bias;
    int amp;
    int n;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: dec = 15'($urandom_range(1, 3));
        5: dec = 15'($urandom_range(4, 16));
        6: dec = '0;
        7: dec = 15'(DEC_MAX);
        8: dec = 15'($urandom_range(65, 127));
        default: dec = 15'($urandom_range(17, 63));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: g = 15'($urandom_range(1, 30));
        4: g = '0;
        5: g = 15'd1023;
        default: g = 15'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: lim = 15'($urandom_range(1000, 32767));
        5: lim = 15'd32767;
        6: lim = '0;
        7: lim = 15'd1;
        default: lim = 15'($urandom_range(0, 32767));
      endcase
      // junk in the unused upper data bits
      dec[14:7] = 8'($urandom);
      g[14:10] = 5'($urandom);
      bias = $urandom_range(0, 16000) - 8000;
      amp = $urandom_range(1, 4000);
      n = $urandom_range(120, 160);
      drain_and_settle();
      set_config(dec, g, lim);
      for (int i = 0; i < n; i++) send_item(gen_raw(bias, amp));
    end
  endtask

  task automatic test_steady_stream;
    int bias;
    drain_and_settle();
    calm = 1'b1;
    set_config(15'd1, 15'($urandom_range(1, 40)), 15'd32767);
    bias = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < 230; i++) send_item(gen_raw(bias, 3000));
  endtask

  // result checker with random back-pressure
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: sample %0d level %0d valid %0b",
               $signed(out_conditioned_sample), out_level, out_level_valid);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_conditioned_sample !== want.sample) begin
          $error("conditioned_sample: expected %0d, got %0d",
                 $signed(want.sample), $signed(out_conditioned_sample));
          mismatches++;
        end
        if (out_level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_level);
          mismatches++;
        end
        if (out_level_valid !== want.level_valid) begin
          $error("level_valid: expected %0b, got %0b", want.level_valid, out_level_valid);
          mismatches++;
        end
      end
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (calm) begin
      out_pop <= 1'b1;
    end else if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else if ($urandom_range(0, 5) == 0) begin
      pop_hold = $urandom_range(1, 9) - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_raw_extremes();
    test_gain_and_limit();
    test_decimation_bounds();
    test_random_settings();
    test_steady_stream();
    drain_and_settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
